// ===== design/position_pnl_tracker_unit_macros.svh =====
// Assertion macros shared by the position tracker RTL.
// Used by ppt_alu and position_pnl_tracker_unit; no other dependencies.
`ifndef POSITION_PNL_TRACKER_UNIT_MACROS_SVH
`define POSITION_PNL_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PPT_ASSERT_IMP(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("ppt assertion failed");

// Next-cycle implication, disabled in reset.
`define PPT_ASSERT_NXT(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("ppt assertion failed");

`endif

// ===== design/ppt_pkg.sv =====
// Package for the position and P&L tracker: payload structs, codes,
// table row type and symbol trimming. No dependencies.
`default_nettype none
package ppt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int SYMBOL_CHARS_DEF  = 8;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [6:0] MUL_LAST = 7'd63;
    localparam logic [6:0] DIV_LAST = 7'd127;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] symbol_key;
        logic        is_sell;
        logic [31:0] quantity;
        logic [47:0] price;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] net_pos;
        logic [47:0]        average_price;
        logic signed [63:0] pnl_realized;
        logic signed [63:0] unrealized_pnl;
        logic signed [63:0] total_pnl;
        logic [63:0]        bought_total;
        logic [63:0]        sold_total;
    } rsp_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] position;
        logic [47:0] average;
        logic [63:0] bought;
        logic [63:0] sold;
        logic [63:0] realized;
    } row_t;

    typedef enum logic {ALU_MUL = 1'b0, ALU_DIV = 1'b1} alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    // Keep bytes up to the first NUL within chars, then drop trailing spaces.
    function automatic logic [63:0] trim_key(input logic [63:0] raw, input int chars);
        logic [63:0] res;
        logic        stop;
        int          n;
        res  = '0;
        stop = 1'b0;
        n    = 0;
        for (int i = 0; i < 8; i++) begin
            if (!stop && i < chars && raw[63-8*i -: 8] != 8'd0) begin
                n = i + 1;
            end else begin
                stop = 1'b1;
            end
        end
        for (int i = 7; i >= 0; i--) begin
            if (n == i + 1 && raw[63-8*i -: 8] == SPACE_CHAR) begin
                n = i;
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                res[63-8*i -: 8] = raw[63-8*i -: 8];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/ppt_alu.sv =====
// Shared serial arithmetic unit: shift-add multiply (64 steps) and
// restoring divide of 128 by 65 bits (128 steps). Uses ppt_pkg.
`default_nettype none
`include "position_pnl_tracker_unit_macros.svh"
module ppt_alu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ppt_pkg::alu_cmd_t cmd,
    input  wire logic [127:0]     opa,
    input  wire logic [64:0]      opb,
    output logic                  busy,
    output logic                  done,
    output logic [127:0]          result
);
    import ppt_pkg::*;

    logic          busy_reg;
    logic          done_reg;
    alu_op_t       op_reg;
    logic [6:0]    cnt_reg;
    logic [127:0]  acc_reg;
    logic [127:0]  mcand_reg;
    logic [63:0]   mplier_reg;
    logic [64:0]   rem_reg;
    logic [64:0]   dvsr_reg;
    logic [65:0]   rem_sh;
    logic [66:0]   diff;

    assign rem_sh = {rem_reg, acc_reg[127]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
            if (cmd.op == ALU_MUL) begin
                cnt_reg    <= MUL_LAST;
                acc_reg    <= '0;
                mcand_reg  <= opa;
                mplier_reg <= opb[63:0];
            end else begin
                cnt_reg  <= DIV_LAST;
                acc_reg  <= opa;
                rem_reg  <= '0;
                dvsr_reg <= opb;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 7'd1;
            if (op_reg == ALU_MUL) begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[126:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[63:1]};
            end else begin
                // Subtract when no borrow, shift the quotient bit in.
                if (!diff[66]) begin
                    rem_reg <= diff[64:0];
                end else begin
                    rem_reg <= rem_sh[64:0];
                end
                acc_reg <= {acc_reg[126:0], ~diff[66]};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

    `PPT_ASSERT_IMP(a_start_when_free, clk, rst_n, cmd.start, !busy_reg)
    `PPT_ASSERT_IMP(a_done_after_busy, clk, rst_n, done_reg, !busy_reg && $past(busy_reg))
    `PPT_ASSERT_NXT(a_last_step_done, clk, rst_n, busy_reg && cnt_reg == 7'd0, done_reg)

endmodule
`default_nettype wire

// ===== design/ppt_table.sv =====
// Position table: one memory row per symbol plus per-entry valid flops.
// Registered read, single write port, whole-table clear. Uses ppt_pkg.
`default_nettype none
module ppt_table #(
    parameter int TABLE_ENTRIES = ppt_pkg::TABLE_ENTRIES_DEF,
    parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [AW-1:0]   rd_addr,
    output ppt_pkg::row_t        rd_row,
    output logic                 rd_valid,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ppt_pkg::row_t   wr_row,
    input  wire logic            clear
);
    import ppt_pkg::*;

    row_t                     mem [TABLE_ENTRIES];
    row_t                     rd_row_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_row   = rd_row_reg;
    assign rd_valid = valid_reg[rd_addr];

endmodule
`default_nettype wire

// ===== design/position_pnl_tracker_unit.sv =====
// Position and P&L tracker top level: sequencer, table and shared ALU.
// Uses ppt_pkg, ppt_table, ppt_alu and the assertion macro header.
//
// Usage: a request enters on req_valid/req_stall/req_data (ppt_pkg::req_t)
// and gives exactly one result on res_valid/res_stall/res_data.
// One request is worked on at a time; req_stall is high from acceptance
// until the result is moved into the output register.
// Work per request, N = TABLE_ENTRIES:
//   clear, zero-quantity fill, unused opcode: straight to the output state.
//   query: scan of up to N rows, then one 64-step multiply on a hit.
//   sell: scan of up to N rows, then two serial multiplies.
//   buy onto an existing position: scan of up to N rows, then three 64-step
//   multiplies and a 128-step divide through the one shared ALU.
// The table scan reads each memory row in S_RD and compares it in S_CMP;
// the serial ALU retires one bit per cycle.
// Reset clears all valid flags at once, so the table is empty and the block
// takes requests from the first cycle after reset.
// When the receiver stalls, the result holds in the output register and the
// next request is still accepted and worked on; it waits in the final state
// until the output register frees.
`default_nettype none
`include "position_pnl_tracker_unit_macros.svh"
module position_pnl_tracker_unit #(
    parameter int TABLE_ENTRIES = ppt_pkg::TABLE_ENTRIES_DEF,
    parameter int SYMBOL_CHARS  = ppt_pkg::SYMBOL_CHARS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ppt_pkg::req_t req_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output ppt_pkg::rsp_t      res_data
);
    import ppt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010,
        S_CMP    = 11'b00000000100,
        S_DECIDE = 11'b00000001000,
        S_MUL1   = 11'b00000010000,
        S_MUL2   = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_SELL   = 11'b00010000000,
        S_WB     = 11'b00100000000,
        S_UNR    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [63:0]    key_reg, key_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  ent_idx_reg, ent_idx_next;
    logic [AW-1:0]  free_idx_reg, free_idx_next;
    logic           found_reg, found_next;
    logic           free_found_reg, free_found_next;
    row_t           row_reg, row_next;
    logic [127:0]   num_reg, num_next;
    rsp_t           rsp_reg, rsp_next;
    rsp_t           res_reg, res_next;
    logic           res_valid_reg, res_valid_next;
    alu_cmd_t       alu_cmd_reg, alu_cmd_next;
    logic [127:0]   opa_reg, opa_next;
    logic [64:0]    opb_reg, opb_next;

    row_t           tbl_rd_row;
    logic           tbl_rd_valid;
    logic           tbl_wr;
    logic           tbl_clear;
    logic           alu_busy;
    logic           alu_done;
    logic [127:0]   alu_result;

    row_t           cur;
    logic [63:0]    qty64;
    logic [63:0]    price64;
    logic [63:0]    diff64;
    logic [127:0]   num_sum;
    logic [64:0]    bought_sum;
    logic [63:0]    unreal;

    ppt_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .AW           (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_reg),
        .rd_row  (tbl_rd_row),
        .rd_valid(tbl_rd_valid),
        .wr_en   (tbl_wr),
        .wr_addr (ent_idx_reg),
        .wr_row  (row_reg),
        .clear   (tbl_clear)
    );

    ppt_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd_reg),
        .opa   (opa_reg),
        .opb   (opb_reg),
        .busy  (alu_busy),
        .done  (alu_done),
        .result(alu_result)
    );

    assign qty64      = {32'd0, req_reg.quantity};
    assign price64    = {16'd0, req_reg.price};
    assign diff64     = price64 - {16'd0, row_reg.average};
    assign num_sum    = num_reg + alu_result;
    assign bought_sum = {1'b0, row_reg.bought} + {1'b0, qty64};
    assign unreal     = alu_result[63:0];

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        ent_idx_next    = ent_idx_reg;
        free_idx_next   = free_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        row_next        = row_reg;
        num_next        = num_reg;
        rsp_next        = rsp_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        alu_cmd_next    = '{start: 1'b0, op: ALU_MUL};
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        tbl_wr          = 1'b0;
        tbl_clear       = 1'b0;
        cur             = row_reg;

        if (res_valid_reg && !res_stall) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next        = req_data;
                    key_next        = trim_key(req_data.symbol_key, SYMBOL_CHARS);
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    rsp_next        = '0;
                    case (req_data.opcode)
                        OP_CLEAR: begin
                            tbl_clear  = 1'b1;
                            state_next = S_OUT;
                        end
                        OP_QUERY: begin
                            state_next = S_RD;
                        end
                        OP_FILL: begin
                            if (req_data.quantity == 32'd0) begin
                                rsp_next.status = ST_ZERO;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (tbl_rd_valid && tbl_rd_row.key == key_reg) begin
                    found_next   = 1'b1;
                    ent_idx_next = idx_reg;
                    row_next     = tbl_rd_row;
                    state_next   = S_DECIDE;
                end else begin
                    // Remember the lowest free entry for allocation.
                    if (!tbl_rd_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_DECIDE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_DECIDE: begin
                if (req_reg.opcode == OP_QUERY) begin
                    if (found_reg) begin
                        alu_cmd_next = '{start: 1'b1, op: ALU_MUL};
                        opa_next     = {64'd0, diff64};
                        opb_next     = {1'b0, row_reg.position};
                        state_next   = S_UNR;
                    end else begin
                        rsp_next.status = ST_MISS;
                        state_next      = S_OUT;
                    end
                end else if (!found_reg && !free_found_reg) begin
                    rsp_next.status = ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    if (!found_reg) begin
                        cur          = '0;
                        cur.key      = key_reg;
                        ent_idx_next = free_idx_reg;
                    end
                    row_next = cur;
                    if (!req_reg.is_sell) begin
                        if (cur.bought == 64'd0) begin
                            // First buy takes the fill price.
                            row_next.average  = req_reg.price;
                            row_next.position = cur.position + qty64;
                            row_next.bought   = cur.bought + qty64;
                            state_next        = S_WB;
                        end else begin
                            alu_cmd_next = '{start: 1'b1, op: ALU_MUL};
                            opa_next     = {80'd0, cur.average};
                            opb_next     = {1'b0, cur.bought};
                            state_next   = S_MUL1;
                        end
                    end else begin
                        alu_cmd_next = '{start: 1'b1, op: ALU_MUL};
                        opa_next     = {64'd0, price64 - {16'd0, cur.average}};
                        opb_next     = {1'b0, qty64};
                        state_next   = S_SELL;
                    end
                end
            end
            S_MUL1: begin
                if (alu_done) begin
                    num_next     = alu_result;
                    alu_cmd_next = '{start: 1'b1, op: ALU_MUL};
                    opa_next     = {64'd0, price64};
                    opb_next     = {1'b0, qty64};
                    state_next   = S_MUL2;
                end
            end
            S_MUL2: begin
                if (alu_done) begin
                    alu_cmd_next = '{start: 1'b1, op: ALU_DIV};
                    opa_next     = num_sum;
                    opb_next     = bought_sum;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_done) begin
                    row_next.average  = alu_result[47:0];
                    row_next.position = row_reg.position + qty64;
                    row_next.bought   = bought_sum[63:0];
                    state_next        = S_WB;
                end
            end
            S_SELL: begin
                if (alu_done) begin
                    row_next.realized = row_reg.realized + alu_result[63:0];
                    row_next.position = row_reg.position - qty64;
                    row_next.sold     = row_reg.sold + qty64;
                    state_next        = S_WB;
                end
            end
            S_WB: begin
                tbl_wr       = 1'b1;
                alu_cmd_next = '{start: 1'b1, op: ALU_MUL};
                opa_next     = {64'd0, diff64};
                opb_next     = {1'b0, row_reg.position};
                state_next   = S_UNR;
            end
            S_UNR: begin
                if (alu_done) begin
                    rsp_next.status         = ST_OK;
                    rsp_next.net_pos        = row_reg.position;
                    rsp_next.average_price  = row_reg.average;
                    rsp_next.pnl_realized   = row_reg.realized;
                    rsp_next.unrealized_pnl = unreal;
                    rsp_next.total_pnl      = row_reg.realized + unreal;
                    rsp_next.bought_total   = row_reg.bought;
                    rsp_next.sold_total     = row_reg.sold;
                    state_next              = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!res_valid_reg || !res_stall) begin
                    res_next       = rsp_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            alu_cmd_reg   <= '{start: 1'b0, op: ALU_MUL};
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            alu_cmd_reg   <= alu_cmd_next;
        end
    end

    always_ff @(posedge clk) begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        ent_idx_reg    <= ent_idx_next;
        free_idx_reg   <= free_idx_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        row_reg        <= row_next;
        num_reg        <= num_next;
        rsp_reg        <= rsp_next;
        res_reg        <= res_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    `PPT_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `PPT_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, req_valid && !req_stall, state_reg != S_IDLE)
    `PPT_ASSERT_IMP(a_wb_has_entry, clk, rst_n, state_reg == S_WB, found_reg || free_found_reg)
    `PPT_ASSERT_IMP(a_alu_not_overrun, clk, rst_n, alu_cmd_reg.start, !alu_busy)

endmodule
`default_nettype wire
